// ----- rtl/core/kttc_pkg.sv -----
// Package for the keyed tree count table: field widths, status and action
// codes, and the layout of one table entry as it sits in memory.
// No dependencies.
package kttc_pkg;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 16;
    localparam int AMT_W    = 16;
    localparam int PRICE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 24;
    localparam int SLOT_W   = 10;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TAKE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // one table slot; used is cleared by the sweep after reset
    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [PRICE_W-1:0] price;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/core/kttc_if.sv -----
// Handshake interfaces for the request and result channels of the table.
// Depends on kttc_pkg.
interface kttc_in_if import kttc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    item_key;
    logic [AMT_W-1:0]    amount;
    logic [PRICE_W-1:0]  unit_price;

    modport source (output valid, action, item_key, amount, unit_price, input ready);
    modport sink   (input valid, action, item_key, amount, unit_price, output ready);
endinterface

interface kttc_out_if import kttc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count_after;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, status, count_after, slot_index, input ready);
    modport sink   (input valid, status, count_after, slot_index, output ready);
endinterface

// ----- rtl/core/kttc_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module kttc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/keyed_tree_count_table_unit.sv -----
// Keyed count table held as an implicit binary search tree in one RAM.
// Depends on kttc_pkg, kttc_in_if / kttc_out_if and kttc_ram.
//
// Usage:
//   request : one word per operation (action, item_key, amount, unit_price).
//             Insert places a new entry, take subtracts if the count
//             suffices, add adds with saturation.
//   result  : one word per request (status, count_after, slot_index).
// Each tree level issues the RAM read at the midpoint, then compares the
// registered entry and narrows the range. The search visits at most
// clog2(TABLE_SLOTS)+1 levels (eleven at 1024 slots); an unused action code
// goes straight to the result. One operation is in flight at a time; the
// next request is taken once the result has moved into the output register,
// even while that result is still waiting to be taken.
// If the receiver stalls, the result holds and the following operation
// waits in its final step until the output register frees up.
// After reset the block sweeps the RAM to mark every slot empty, one slot
// per cycle; request.ready stays low during the sweep.
module keyed_tree_count_table_unit import kttc_pkg::*; #(
    parameter int TABLE_SLOTS = 1024
) (
    input logic        clk,
    input logic        rst_n,
    kttc_in_if.sink    request,
    kttc_out_if.source result
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // control state
    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                out_valid_reg, out_valid_next;

    // operation and search state
    logic [ACTION_W-1:0] action_reg, action_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [AMT_W-1:0]    amt_reg, amt_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       end_reg, end_next;   // exclusive upper bound
    logic [AW-1:0]       mid_reg, mid_next;
    logic                matched_reg, matched_next;
    logic [COUNT_W-1:0]  last_count_reg, last_count_next;
    logic [AW-1:0]       last_slot_reg, last_slot_next;

    // pending result and output register
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;
    logic [AW-1:0]       res_slot_reg, res_slot_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;

    // RAM port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [CW-1:0]       span;
    logic [CW-1:0]       mid_full;
    logic [CW-1:0]       mid_ext;
    logic [COUNT_W:0]    sum;
    entry_t              rd_entry;
    entry_t              wr_entry;

    kttc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // midpoint of the live range and helpers
    assign span     = end_reg - lo_reg - CW'(1);
    assign mid_full = lo_reg + (span >> 1);
    assign mid_ext  = CW'(mid_reg);
    assign rd_entry = entry_t'(ram_rdata);
    assign sum      = {1'b0, rd_entry.count} + (COUNT_W + 1)'(amt_reg);
    assign ram_wdata = wr_entry;

    assign request.ready      = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.count_after = out_count_reg;
    assign result.slot_index  = out_slot_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        amt_next        = amt_reg;
        price_next      = price_reg;
        lo_next         = lo_reg;
        end_next        = end_reg;
        mid_next        = mid_reg;
        matched_next    = matched_reg;
        last_count_next = last_count_reg;
        last_slot_next  = last_slot_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        res_slot_next   = res_slot_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_slot_next   = out_slot_reg;

        ram_we    = 1'b0;
        ram_waddr = mid_reg;
        ram_raddr = mid_full[AW-1:0];
        wr_entry  = rd_entry;

        // result taken by the receiver
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = clr_cnt_reg;
                wr_entry       = '0;
                clr_cnt_next   = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (request.valid)
                begin
                    action_next  = request.action;
                    key_next     = request.item_key;
                    amt_next     = request.amount;
                    price_next   = request.unit_price;
                    lo_next      = '0;
                    end_next     = CW'(TABLE_SLOTS);
                    matched_next = 1'b0;
                    if (request.action == ACT_INSERT || request.action == ACT_TAKE ||
                        request.action == ACT_ADD)
                    begin
                        state_next = S_LOOKUP;
                    end
                    else
                    begin
                        // unused action code: nothing touched
                        res_status_next = ST_NOT_FOUND;
                        res_count_next  = '0;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_LOOKUP:
            begin
                if (lo_reg < end_reg)
                begin
                    mid_next   = mid_full[AW-1:0];
                    state_next = S_CHECK;
                end
                else
                begin
                    // range exhausted
                    if (action_reg == ACT_INSERT)
                    begin
                        res_status_next = ST_NO_ROOM;
                        res_count_next  = '0;
                        res_slot_next   = '0;
                    end
                    else if (matched_reg)
                    begin
                        res_status_next = ST_SHORT;
                        res_count_next  = last_count_reg;
                        res_slot_next   = last_slot_reg;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_count_next  = '0;
                        res_slot_next   = '0;
                    end
                    state_next = S_DONE;
                end
            end

            S_CHECK:
            begin
                // default: narrow the range, equal keys go right
                if (key_reg < rd_entry.key)
                begin
                    end_next = mid_ext;
                end
                else
                begin
                    lo_next = mid_ext + CW'(1);
                end
                state_next = S_LOOKUP;

                if (!rd_entry.used)
                begin
                    state_next = S_DONE;
                    if (action_reg == ACT_INSERT)
                    begin
                        ram_we          = 1'b1;
                        wr_entry.used   = 1'b1;
                        wr_entry.key    = key_reg;
                        wr_entry.count  = COUNT_W'(amt_reg);
                        wr_entry.price  = price_reg;
                        res_status_next = ST_OK;
                        res_count_next  = COUNT_W'(amt_reg);
                        res_slot_next   = mid_reg;
                    end
                    else if (matched_reg)
                    begin
                        res_status_next = ST_SHORT;
                        res_count_next  = last_count_reg;
                        res_slot_next   = last_slot_reg;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_count_next  = '0;
                        res_slot_next   = '0;
                    end
                end
                else if (action_reg != ACT_INSERT && rd_entry.key == key_reg)
                begin
                    if (action_reg == ACT_TAKE)
                    begin
                        if (rd_entry.count >= COUNT_W'(amt_reg))
                        begin
                            ram_we          = 1'b1;
                            wr_entry.count  = rd_entry.count - COUNT_W'(amt_reg);
                            res_status_next = ST_OK;
                            res_count_next  = rd_entry.count - COUNT_W'(amt_reg);
                            res_slot_next   = mid_reg;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // short: remember it, keep looking for a duplicate
                            matched_next    = 1'b1;
                            last_count_next = rd_entry.count;
                            last_slot_next  = mid_reg;
                        end
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        if (sum[COUNT_W])
                        begin
                            wr_entry.count = COUNT_MAX;
                            res_count_next = COUNT_MAX;
                        end
                        else
                        begin
                            wr_entry.count = sum[COUNT_W-1:0];
                            res_count_next = sum[COUNT_W-1:0];
                        end
                        res_status_next = ST_OK;
                        res_slot_next   = mid_reg;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                // move into the output register once it is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_count_next  = res_count_reg;
                    out_slot_next   = SLOT_W'(res_slot_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        key_reg        <= key_next;
        amt_reg        <= amt_next;
        price_reg      <= price_next;
        lo_reg         <= lo_next;
        end_reg        <= end_next;
        mid_reg        <= mid_next;
        matched_reg    <= matched_next;
        last_count_reg <= last_count_next;
        last_slot_reg  <= last_slot_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_slot_reg   <= out_slot_next;
    end

endmodule

// ----- rtl/core/kttc_checker.sv -----
// Port-level checker for the keyed tree count table, bound to the top level.
// Depends on kttc_pkg and keyed_tree_count_table_unit.
module kttc_checker import kttc_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] out_status,
    input logic [COUNT_W-1:0]  out_count,
    input logic [SLOT_W-1:0]   out_slot
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) &&
        $stable(out_count) && $stable(out_slot))
        else $error("result word changed while stalled");

    // one operation at a time: no request taken right after another
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while an operation is in flight");

    // no room touches no entry
    a_no_room_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == ST_NO_ROOM |-> out_count == '0 && out_slot == '0)
        else $error("no-room result carries an entry");

    // not found touches no entry
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == ST_NOT_FOUND |-> out_count == '0 && out_slot == '0)
        else $error("not-found result carries an entry");

endmodule

bind keyed_tree_count_table_unit kttc_checker u_kttc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (request.valid),
    .in_ready   (request.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_status (result.status),
    .out_count  (result.count_after),
    .out_slot   (result.slot_index)
);
